// ===== hw/rtl/cfba_pkg.sv =====
// Shared types and constants for the chunked fixed-block allocator.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package cfba_pkg;

    // Default sizing of the allocator.
    localparam int DEF_MAX_CHUNKS = 8;
    localparam int DEF_MAX_BLOCKS = 255;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_BPC = 2'd0;  // blocks_per_chunk
    localparam logic [CFG_IDX_W-1:0] REG_BSZ = 2'd1;  // block_size

    // Register reset values.
    localparam logic [7:0]  BPC_RESET = 8'd255;
    localparam logic [12:0] BSZ_RESET = 13'd8;

    // Request codes.
    localparam logic FN_FREE = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic       func;
        logic [2:0] free_chunk;
        logic [7:0] free_block;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  out_chunk;
        logic [7:0]  out_block;
        logic [19:0] byte_offset;
    } t_rsp;

    // One row of the chunk table.
    typedef struct packed {
        logic [7:0] head;
        logic [7:0] avail;
        logic [7:0] blocks;
    } t_chunk_ent;

endpackage

`default_nettype wire

// ===== hw/rtl/chunked_fixed_block_allocator_top.sv =====
// Chunked fixed-block allocator: sequencer, config registers, link store and chunk table.
// Depends on cfba_pkg, cfba_link_ram and cfba_chunk_ram.
// Throughput: one item at a time; an allocate from a chunk in use passes S_ALLOC_HEAD and
//   S_ALLOC_UPD, a free that reaches the block check passes S_FREE_CHK, and S_OUT waits on i_stall.
// Output: o_valid rises when S_OUT moves the finished result into the output register.
// Reset: synchronous; a clearing pass then rewrites all MAX_CHUNKS*256 links, o_stall high.
`timescale 1ns / 1ps
`default_nettype none

module chunked_fixed_block_allocator_top #(
    parameter int MAX_CHUNKS = cfba_pkg::DEF_MAX_CHUNKS,
    parameter int MAX_BLOCKS = cfba_pkg::DEF_MAX_BLOCKS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire cfba_pkg::t_req                i_data,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output cfba_pkg::t_rsp                     o_data,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [cfba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cfba_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // chunk index, chunk count and link address widths
    localparam int CIW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNW   = $clog2(MAX_CHUNKS + 1);
    localparam int SLOTS = MAX_CHUNKS * 256;
    localparam int AW    = CIW + 8;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_HEAD,
        S_ALLOC_UPD,
        S_FREE_CHK,
        S_OUT
    } t_state;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state                r_state,    n_state;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic [CNW-1:0]        r_in_use,   n_in_use;     // chunks brought into use
    logic [CIW-1:0]        r_cur,      n_cur;        // current chunk
    logic                  r_cur_vld,  n_cur_vld;
    logic [MAX_CHUNKS-1:0] r_nz,       n_nz;         // chunk has free blocks
    logic [CIW-1:0]        r_chunk,    n_chunk;      // chunk of the item at work
    logic [7:0]            r_fb,       n_fb;         // block named by a free
    logic [7:0]            r_blk,      n_blk;        // block taken by an allocate
    cfba_pkg::t_rsp        r_res,      n_res;        // finished result
    cfba_pkg::t_rsp        r_out,      n_out;        // output register
    logic                  r_out_vld,  n_out_vld;
    logic [7:0]            r_bpc,      n_bpc;        // blocks_per_chunk
    logic [12:0]           r_bsz,      n_bsz;        // block_size

    // ---------------------------------------------------------------
    // Memory ports
    // ---------------------------------------------------------------
    logic                 lnk_we, lnk_re;
    logic [AW-1:0]        lnk_waddr, lnk_raddr;
    logic [7:0]           lnk_wdata, lnk_rdata;

    logic                 tbl_we, tbl_re;
    logic [CIW-1:0]       tbl_waddr, tbl_raddr;
    cfba_pkg::t_chunk_ent tbl_wdata, tbl_rdata;

    cfba_link_ram #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_re    (lnk_re),
        .i_raddr (lnk_raddr),
        .o_rdata (lnk_rdata)
    );

    cfba_chunk_ram #(
        .DEPTH (MAX_CHUNKS),
        .AW    (CIW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // ---------------------------------------------------------------
    // Chunk selection for an allocate
    // ---------------------------------------------------------------
    logic [MAX_CHUNKS-1:0] lowest_nz;
    logic [CIW-1:0]        scan_idx;
    logic                  scan_found;
    logic                  cur_hit;
    logic [CIW-1:0]        pick;
    logic                  free_ok;
    logic [7:0]            bpc_eff;
    logic [CIW-1:0]        fresh_idx;
    logic [7:0]            avail_dec, avail_inc;
    logic [20:0]           blk_off;

    // Isolate the lowest chunk with free blocks; only chunks in use ever have a flag.
    always_comb begin
        lowest_nz = r_nz & (~r_nz + MAX_CHUNKS'(1));
        scan_idx  = '0;
        for (int i = 0; i < MAX_CHUNKS; i++) begin
            if (lowest_nz[i]) begin
                scan_idx = scan_idx | CIW'(i);
            end
        end
    end

    assign scan_found = |r_nz;
    assign cur_hit    = r_cur_vld && r_nz[r_cur];
    assign pick       = cur_hit ? r_cur : scan_idx;

    // A free must name a chunk already in use.
    assign free_ok = ({{CNW{1'b0}}, i_data.free_chunk} < {3'b000, r_in_use});

    // Block count of a fresh chunk: zero counts as one, clamp at MAX_BLOCKS.
    assign bpc_eff = (r_bpc == 8'd0)              ? 8'd1 :
                     (r_bpc > 8'(MAX_BLOCKS))     ? 8'(MAX_BLOCKS) : r_bpc;
    assign fresh_idx = CIW'(r_in_use);

    assign avail_dec = tbl_rdata.avail - 8'd1;
    assign avail_inc = tbl_rdata.avail + 8'd1;

    // full 21-bit product; the result keeps the low 20 bits
    assign blk_off = {13'd0, r_blk} * {8'd0, r_bsz};

    // ---------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_in_use   = r_in_use;
        n_cur      = r_cur;
        n_cur_vld  = r_cur_vld;
        n_nz       = r_nz;
        n_chunk    = r_chunk;
        n_fb       = r_fb;
        n_blk      = r_blk;
        n_res      = r_res;
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        n_bpc      = r_bpc;
        n_bsz      = r_bsz;

        lnk_we    = 1'b0;
        lnk_waddr = {r_chunk, r_fb};
        lnk_wdata = tbl_rdata.head;
        lnk_re    = 1'b0;
        lnk_raddr = {r_chunk, tbl_rdata.head};

        tbl_we    = 1'b0;
        tbl_waddr = r_chunk;
        tbl_wdata = tbl_rdata;
        tbl_re    = 1'b0;
        tbl_raddr = r_chunk;

        // drop the output item once taken
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        // configuration writes are taken in every cycle
        if (i_cfg_valid) begin
            case (i_cfg_index)
                cfba_pkg::REG_BPC: n_bpc = i_cfg_data[7:0];
                cfba_pkg::REG_BSZ: n_bsz = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                // rewrite each link with its successor slot
                lnk_we    = 1'b1;
                lnk_waddr = r_clr_addr;
                lnk_wdata = r_clr_addr[7:0] + 8'd1;
                if (r_clr_addr == AW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end

            S_IDLE: begin
                if (i_valid) begin
                    n_fb = i_data.free_block;
                    if (i_data.func == cfba_pkg::FN_FREE) begin
                        if (free_ok) begin
                            tbl_re    = 1'b1;
                            tbl_raddr = CIW'(i_data.free_chunk);
                            n_chunk   = CIW'(i_data.free_chunk);
                            n_state   = S_FREE_CHK;
                        end else begin
                            n_res   = '{status: cfba_pkg::ST_RANGE, out_chunk: 3'd0,
                                        out_block: 8'd0, byte_offset: 20'd0};
                            n_state = S_OUT;
                        end
                    end else if (cur_hit || scan_found) begin
                        // take the head of a chunk in use
                        tbl_re    = 1'b1;
                        tbl_raddr = pick;
                        n_chunk   = pick;
                        n_cur     = pick;
                        n_cur_vld = 1'b1;
                        n_state   = S_ALLOC_HEAD;
                    end else if (r_in_use != CNW'(MAX_CHUNKS)) begin
                        // fresh chunk: its links still hold slot+1, so block 0 goes
                        // out and the head advances to 1 without a link read
                        tbl_we          = 1'b1;
                        tbl_waddr       = fresh_idx;
                        tbl_wdata       = '{head: 8'd1, avail: bpc_eff - 8'd1,
                                            blocks: bpc_eff};
                        n_nz[fresh_idx] = (bpc_eff != 8'd1);
                        n_cur           = fresh_idx;
                        n_cur_vld       = 1'b1;
                        n_in_use        = r_in_use + CNW'(1);
                        n_res           = '{status: cfba_pkg::ST_OK,
                                            out_chunk: 3'(fresh_idx),
                                            out_block: 8'd0, byte_offset: 20'd0};
                        n_state         = S_OUT;
                    end else begin
                        n_res   = '{status: cfba_pkg::ST_FULL, out_chunk: 3'd0,
                                    out_block: 8'd0, byte_offset: 20'd0};
                        n_state = S_OUT;
                    end
                end
            end

            S_ALLOC_HEAD: begin
                // read the link behind the head block
                lnk_re    = 1'b1;
                lnk_raddr = {r_chunk, tbl_rdata.head};
                n_blk     = tbl_rdata.head;
                n_state   = S_ALLOC_UPD;
            end

            S_ALLOC_UPD: begin
                // advance the head, count the block out
                tbl_we        = 1'b1;
                tbl_waddr     = r_chunk;
                tbl_wdata     = '{head: lnk_rdata, avail: avail_dec,
                                  blocks: tbl_rdata.blocks};
                n_nz[r_chunk] = (avail_dec != 8'd0);
                n_res         = '{status: cfba_pkg::ST_OK, out_chunk: 3'(r_chunk),
                                  out_block: r_blk, byte_offset: blk_off[19:0]};
                n_state       = S_OUT;
            end

            S_FREE_CHK: begin
                if (r_fb < tbl_rdata.blocks) begin
                    // push the block on its chunk's list
                    lnk_we        = 1'b1;
                    lnk_waddr     = {r_chunk, r_fb};
                    lnk_wdata     = tbl_rdata.head;
                    tbl_we        = 1'b1;
                    tbl_waddr     = r_chunk;
                    tbl_wdata     = '{head: r_fb, avail: avail_inc,
                                      blocks: tbl_rdata.blocks};
                    n_nz[r_chunk] = (avail_inc != 8'd0);
                    n_res         = '{status: cfba_pkg::ST_OK, out_chunk: 3'd0,
                                      out_block: 8'd0, byte_offset: 20'd0};
                end else begin
                    n_res = '{status: cfba_pkg::ST_RANGE, out_chunk: 3'd0,
                              out_block: 8'd0, byte_offset: 20'd0};
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                // hold the result until the output register is free
                if (!r_out_vld || !i_stall) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // State and registered outputs
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_in_use   <= '0;
            r_cur      <= '0;
            r_cur_vld  <= 1'b0;
            r_nz       <= '0;
            r_out_vld  <= 1'b0;
            r_bpc      <= cfba_pkg::BPC_RESET;
            r_bsz      <= cfba_pkg::BSZ_RESET;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_in_use   <= n_in_use;
            r_cur      <= n_cur;
            r_cur_vld  <= n_cur_vld;
            r_nz       <= n_nz;
            r_out_vld  <= n_out_vld;
            r_bpc      <= n_bpc;
            r_bsz      <= n_bsz;
        end
        r_chunk <= n_chunk;
        r_fb    <= n_fb;
        r_blk   <= n_blk;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_vld;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_in_use_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_use <= CNW'(MAX_CHUNKS))
        else $error("more chunks in use than exist");

    a_nz_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nz >> r_in_use) == '0)
        else $error("free flag set on a chunk not in use");

    a_cur_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_vld |-> (CNW'(r_cur) < r_in_use))
        else $error("current chunk not in use");

    a_link_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lnk_we |-> (r_state == S_CLEAR) || (r_state == S_FREE_CHK))
        else $error("link store written outside clear or free");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !(o_valid && $rose(o_valid)))
        else $error("result produced during clearing pass");

endmodule

`default_nettype wire

// ===== hw/rtl/cfba_link_ram.sv =====
// Next-free link store: one 8-bit link per block slot of every chunk.
// Synchronous write, registered read. Uses cfba_pkg for default sizing.
`timescale 1ns / 1ps
`default_nettype none

module cfba_link_ram #(
    parameter int DEPTH = cfba_pkg::DEF_MAX_CHUNKS * 256,
    parameter int AW    = $clog2(cfba_pkg::DEF_MAX_CHUNKS) + 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/cfba_chunk_ram.sv =====
// Chunk table: free-list head, free count and block count per chunk.
// Synchronous write, registered read. Uses cfba_pkg for the row type.
`timescale 1ns / 1ps
`default_nettype none

module cfba_chunk_ram #(
    parameter int DEPTH = cfba_pkg::DEF_MAX_CHUNKS,
    parameter int AW    = (cfba_pkg::DEF_MAX_CHUNKS > 1) ? $clog2(cfba_pkg::DEF_MAX_CHUNKS) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire cfba_pkg::t_chunk_ent i_wdata,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr,
    output cfba_pkg::t_chunk_ent      o_rdata
);

    cfba_pkg::t_chunk_ent r_mem [DEPTH];
    cfba_pkg::t_chunk_ent r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== tb/sv/chunked_fixed_block_allocator_top_tb.sv =====
// Self-checking bench for chunked_fixed_block_allocator_top: allocate/free traffic
// checked against a cycle-free model of the chunk lists kept in a small tracker class.
// Depends on cfba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module chunked_fixed_block_allocator_top_tb;

    localparam logic FN_ALLOC = ~cfba_pkg::FN_FREE;
    localparam int   NCHUNK   = cfba_pkg::DEF_MAX_CHUNKS;

    // Tracks the allocator's free lists, predicts each reply and checks the
    // replies that come back in order.
    class alloc_tracker;
        logic [7:0]     link [NCHUNK*256];
        logic [7:0]     head [NCHUNK];
        logic [7:0]     avail [NCHUNK];
        logic [7:0]     blocks [NCHUNK];
        int             in_use;
        logic [2:0]     cur;
        bit             cur_valid;
        logic [7:0]     bpc;
        logic [12:0]    bsz;
        cfba_pkg::t_rsp replies_due[$];
        logic [10:0]    held[$];     // {chunk, block} handed out and not yet freed
        int             mismatches;
        int             full_seen;
        int             reply_cnt;

        function new();
            for (int k = 0; k < NCHUNK*256; k++) link[k] = k[7:0] + 8'd1;
            for (int c = 0; c < NCHUNK; c++) begin
                head[c] = '0;
                avail[c] = '0;
                blocks[c] = '0;
            end
            in_use = 0;
            cur = '0;
            cur_valid = 0;
            bpc = cfba_pkg::BPC_RESET;
            bsz = cfba_pkg::BSZ_RESET;
            mismatches = 0;
            full_seen = 0;
            reply_cnt = 0;
        endfunction

        function void set_reg(logic [cfba_pkg::CFG_IDX_W-1:0] idx,
                              logic [cfba_pkg::CFG_DATA_W-1:0] val);
            if (idx == cfba_pkg::REG_BPC) bpc = val[7:0];
            else if (idx == cfba_pkg::REG_BSZ) bsz = val[12:0];
        endfunction

        function cfba_pkg::t_rsp predict_reply(cfba_pkg::t_req r);
            cfba_pkg::t_rsp rsp;
            logic [2:0]     c;
            logic [7:0]     b;
            logic [7:0]     n;
            logic [31:0]    prod;
            bit             found;
            rsp = '0;
            if (r.func == cfba_pkg::FN_FREE) begin
                c = r.free_chunk;
                b = r.free_block;
                if (c >= in_use || b >= blocks[c]) begin
                    rsp.status = cfba_pkg::ST_RANGE;
                end else begin
                    link[{c, b}] = head[c];
                    head[c] = b;
                    avail[c] = avail[c] + 8'd1;
                    rsp.status = cfba_pkg::ST_OK;
                end
                return rsp;
            end
            if (!cur_valid || avail[cur] == 0) begin
                found = 0;
                for (int i = 0; i < in_use; i++) begin
                    if (!found && avail[i] != 0) begin
                        cur = i[2:0];
                        cur_valid = 1;
                        found = 1;
                    end
                end
                if (!found) begin
                    if (in_use >= NCHUNK) begin
                        rsp.status = cfba_pkg::ST_FULL;
                        full_seen++;
                        return rsp;
                    end
                    // a zero count still gives one block; clamp at the block cap
                    n = (bpc == 0) ? 8'd1 : bpc;
                    if (n > cfba_pkg::DEF_MAX_BLOCKS) n = 8'(cfba_pkg::DEF_MAX_BLOCKS);
                    c = in_use[2:0];
                    for (int i = 0; i < n; i++) link[{c, i[7:0]}] = i[7:0] + 8'd1;
                    head[c] = '0;
                    avail[c] = n;
                    blocks[c] = n;
                    cur = c;
                    cur_valid = 1;
                    in_use++;
                end
            end
            b = head[cur];
            head[cur] = link[{cur, b}];
            avail[cur] = avail[cur] - 8'd1;
            prod = 32'(b) * 32'(bsz);
            rsp.status = cfba_pkg::ST_OK;
            rsp.out_chunk = cur;
            rsp.out_block = b;
            rsp.byte_offset = prod[19:0];
            held.insert(held.size(), {cur, b});
            return rsp;
        endfunction

        function void note_request(cfba_pkg::t_req r);
            replies_due.insert(replies_due.size(), predict_reply(r));
        endfunction

        function void check_reply(cfba_pkg::t_rsp got);
            cfba_pkg::t_rsp want;
            reply_cnt++;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR reply %0d: none due, got st=%0d c=%0d b=%0d off=%0h",
                             reply_cnt, got.status, got.out_chunk, got.out_block,
                             got.byte_offset);
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status || got.out_chunk !== want.out_chunk ||
                got.out_block !== want.out_block || got.byte_offset !== want.byte_offset) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR reply %0d: exp %0d/%0d/%0d/%0h got %0d/%0d/%0d/%0h",
                             reply_cnt, want.status, want.out_chunk, want.out_block,
                             want.byte_offset, got.status, got.out_chunk, got.out_block,
                             got.byte_offset);
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_valid     = 1'b0;
    logic                            o_stall;
    cfba_pkg::t_req                  i_data      = '0;
    logic                            o_valid;
    logic                            i_stall     = 1'b0;
    cfba_pkg::t_rsp                  o_data;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [cfba_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [cfba_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    alloc_tracker book;
    bit           gaps_on   = 1'b1;
    bit           stall_on  = 1'b1;
    int           stall_left = 0;

    chunked_fixed_block_allocator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Result side back-pressure: random stall bursts with calm stretches in between;
    // drop it entirely when disabled.
    always @(posedge i_clk) begin
        if (!stall_on) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Check every reply taken at an edge; values read here are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) book.check_reply(o_data);
    end

    // Hang guard: far beyond the slowest legal run, including the link-store clear.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // Present one item and hold it until the allocator takes it. Call at a clock edge.
    task automatic send(input cfba_pkg::t_req r);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= r;
        do @(posedge i_clk); while (o_stall);
        book.note_request(r);
    endtask

    task automatic alloc();
        cfba_pkg::t_req r;
        r.func       = FN_ALLOC;
        r.free_chunk = 3'($urandom_range(0, 7));   // ignored on allocate, toggle anyway
        r.free_block = 8'($urandom_range(0, 254));
        send(r);
    endtask

    task automatic free_blk(input logic [2:0] c, input logic [7:0] b);
        cfba_pkg::t_req r;
        r.func       = cfba_pkg::FN_FREE;
        r.free_chunk = c;
        r.free_block = b;
        send(r);
    endtask

    // Return a block the allocator handed out, or fall back to a stray free.
    task automatic free_held();
        int          k;
        logic [10:0] e;
        if (book.held.size() == 0) begin
            free_blk(3'($urandom_range(0, 7)), 8'($urandom_range(0, 254)));
        end else begin
            k = $urandom_range(0, book.held.size() - 1);
            e = book.held[k];
            book.held.delete(k);
            free_blk(e[10:8], e[7:0]);
        end
    endtask

    // Stray free: often a double free or an index out of range.
    task automatic free_noise();
        if ($urandom_range(0, 1) == 0)
            free_blk(3'($urandom_range(0, 7)), 8'($urandom_range(0, 254)));
        else
            free_blk(3'($urandom_range(0, 7)), 8'($urandom_range(0, 3)));
    endtask

    // Drop valid, wait for every outstanding reply, then let the pipeline drain.
    task automatic settle();
        i_valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write both registers back to back; only while the allocator is idle.
    task automatic write_regs(input logic [7:0] bpc, input logic [12:0] bsz);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= cfba_pkg::REG_BPC;
        i_cfg_data  <= {5'd0, bpc};
        do @(posedge i_clk); while (!o_cfg_ready);
        book.set_reg(cfba_pkg::REG_BPC, {5'd0, bpc});
        i_cfg_index <= cfba_pkg::REG_BSZ;
        i_cfg_data  <= bsz;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.set_reg(cfba_pkg::REG_BSZ, bsz);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int          n;
        int          fulls0;
        int          pick;
        logic [12:0] sz;
        book = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // Zero block count: every chunk gets a single block; oversized block size.
        write_regs(8'd0, 13'd8191);
        alloc();                   // chunk 0 comes into use
        alloc();                   // chunk 0 empty, no scan hit: chunk 1 comes in
        free_blk(3'd0, 8'd0);
        free_blk(3'd0, 8'd1);      // index past the chunk's block count
        free_blk(3'd6, 8'd3);      // chunk not yet in use
        free_blk(3'd1, 8'd0);
        free_blk(3'd1, 8'd0);      // double free, pushed again
        alloc();
        alloc();
        alloc();                   // current chunk dry, scan finds chunk 0
        alloc();                   // nothing free: chunk 2 comes in
        settle();

        // One block per chunk for chunks 3..6.
        write_regs(8'd1, 13'd4096);
        repeat (4) alloc();
        settle();

        // Last chunk gets the full block count; top block gives the top offset.
        write_regs(8'd255, 13'd4096);
        alloc();
        free_blk(3'd7, 8'd254);
        alloc();
        free_blk(3'd3, 8'd1);
        settle();

        // Block size out of range: offset of a high block wraps at 20 bits.
        write_regs(8'd17, 13'd8191);
        free_blk(3'd7, 8'd254);
        alloc();
        settle();

        // --- random mix, several register settings ---
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: sz = 13'd1;
                1: sz = 13'd0;
                default: sz = 13'($urandom_range(1, 8191));
            endcase
            write_regs(8'($urandom_range(1, 254)), sz);
            for (int i = 0; i < 30; i++) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) alloc();
                else if (pick < 9) free_held();
                else free_noise();
            end
            settle();
        end

        // --- fill: mostly allocates until the allocator reports full a few times ---
        write_regs(8'($urandom_range(0, 255)), 13'($urandom_range(1, 4096)));
        fulls0 = book.full_seen;
        n = 0;
        while (book.full_seen < fulls0 + 4 && n < 500) begin
            pick = $urandom_range(0, 24);
            if (pick < 23) alloc();
            else if (pick == 23) free_held();
            else free_noise();
            n++;
        end
        settle();

        // --- drain: no idling on either side from here on ---
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        write_regs(8'($urandom_range(0, 255)), 13'($urandom_range(1, 8191)));
        for (int i = 0; i < 100; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) free_held();
            else if (pick < 17) alloc();
            else free_noise();
        end
        settle();

        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
